// File: sv/vlrf_pkg.sv
// Shared types and constants for the variable-length record FIFO.
// No dependencies; imported by vlrf_front, vlrf_back and the top level.
`default_nettype none

package vlrf_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int unsigned BUFFER_BYTES_DEF = 1024;
    localparam int unsigned HEADER_BYTES_DEF = 4;
    localparam int unsigned MAX_DELIVER_DEF  = 63;

    // Fixed field widths
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned NEED_W = 11;
    localparam int unsigned FREE_W = 11;

    // Opcodes on the input word
    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_PEEK  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SEQ   = 2'd3;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_BEGIN = 3'd0,
        K_DATA  = 3'd1,
        K_POP   = 3'd2,
        K_PEEK  = 3'd3,
        K_CLEAR = 3'd4,
        K_BAD   = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [LEN_W-1:0] record_length;
        logic [7:0]       data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic              byte_valid;
        logic [7:0]        data_out;
        logic              last;
        logic [FREE_W-1:0] free_space;
        logic              is_empty;
    } t_out;

    // Classified command queued between front and back
    typedef struct packed {
        t_kind             kind;
        logic [LEN_W-1:0]  len;
        logic [7:0]        data;
        logic              fits;   // length fits in the header bytes
        logic [NEED_W-1:0] need;   // header plus data bytes to reserve
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/vlrf_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on vlrf_pkg.
`default_nettype none

module vlrf_front #(
    parameter int unsigned HEADER_BYTES = vlrf_pkg::HEADER_BYTES_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  vlrf_pkg::t_in   i_in_data,
    output logic            o_cmd_valid,
    input  wire             i_cmd_pop,
    output vlrf_pkg::t_cmd  o_cmd
);
    import vlrf_pkg::*;

    t_cmd       cmd_new;
    t_cmd       r_q [2];
    logic       r_qw, r_qr;
    logic [1:0] r_qcnt;
    logic       push, pop;

    // Classify the incoming word
    always_comb begin
        cmd_new.len  = i_in_data.record_length;
        cmd_new.data = i_in_data.data_byte;
        cmd_new.fits = (HEADER_BYTES >= 2) || (i_in_data.record_length < LEN_W'(256));
        cmd_new.need = NEED_W'(HEADER_BYTES) + NEED_W'(i_in_data.record_length);
        unique case (i_in_data.opcode)
            OP_BEGIN: cmd_new.kind = K_BEGIN;
            OP_DATA:  cmd_new.kind = K_DATA;
            OP_POP:   cmd_new.kind = K_POP;
            OP_PEEK:  cmd_new.kind = K_PEEK;
            OP_CLEAR: cmd_new.kind = K_CLEAR;
            default:  cmd_new.kind = K_BAD;
        endcase
    end

    assign o_in_ready  = (r_qcnt != 2'd2);
    assign o_cmd_valid = (r_qcnt != 2'd0);
    assign o_cmd       = r_q[r_qr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_qw] <= cmd_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw   <= 1'b0;
            r_qr   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (push) begin
                r_qw <= ~r_qw;
            end
            if (pop) begin
                r_qr <= ~r_qr;
            end
            r_qcnt <= r_qcnt + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// File: sv/vlrf_back.sv
// Back end: executes queued commands on the byte ring and delivers results.
// Holds the ring memory and a two-word output buffer. Depends on vlrf_pkg.
`default_nettype none

module vlrf_back #(
    parameter int unsigned BUFFER_BYTES = vlrf_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = vlrf_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_DELIVER  = vlrf_pkg::MAX_DELIVER_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cmd_valid,
    output logic            o_cmd_pop,
    input  vlrf_pkg::t_cmd  i_cmd,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output vlrf_pkg::t_out  o_out_data
);
    import vlrf_pkg::*;

    localparam int unsigned PW   = $clog2(BUFFER_BYTES);
    localparam int unsigned FCW  = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned HDW  = 8 * HEADER_BYTES;
    localparam int unsigned HCW  = $clog2(HEADER_BYTES + 1);
    localparam int unsigned DCW  = $clog2(MAX_DELIVER + 1);
    localparam int unsigned SW   = ((FCW > 12) ? FCW : 12) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HWR   = 5'b00010,
        S_HRD   = 5'b00100,
        S_HEVAL = 5'b01000,
        S_DATA  = 5'b10000
    } t_state;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    // Ring memory
    logic [7:0]     r_mem [BUFFER_BYTES];
    logic [7:0]     r_rd_data;

    // Control state
    t_state           r_state, n_state;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_ra, n_ra;
    logic [FCW-1:0]   r_free, n_free;
    logic [LEN_W-1:0] r_prem, n_prem;
    logic [LEN_W-1:0] r_hsh, n_hsh;
    logic [HCW-1:0]   r_hcnt, n_hcnt;
    logic [HDW-1:0]   r_st, n_st;
    logic             r_is_pop, n_is_pop;
    logic [LEN_W-1:0] r_len, n_len;
    logic [DCW-1:0]   r_left, n_left;
    logic             r_inf, n_inf;
    logic             r_inf_last, n_inf_last;

    // Output buffer
    t_out       r_ob [2];
    logic       r_ow, r_or;
    logic [1:0] r_ocnt;

    // Datapath controls
    logic             wr_en, rd_en;
    logic [PW-1:0]    wr_addr, rd_addr;
    logic [7:0]       wr_data;
    logic             res_push;
    logic [1:0]       res_status;
    logic             res_byte;
    logic [7:0]       res_dout;
    logic             res_last;
    t_out             res;
    logic             out_pop;
    logic [2:0]       used;
    logic             slot_ok, emit_ok;
    logic [LEN_W-1:0] stored, m1;
    logic [DCW-1:0]   n_cnt;
    logic [SW-1:0]    total, rp_sum;

    assign out_pop = (r_ocnt != 2'd0) && i_out_ready;
    assign used    = 3'(r_ocnt) - 3'(out_pop) + 3'(r_inf);
    assign slot_ok = (used < 3'd2);
    assign emit_ok = slot_ok && !r_inf;

    // Header evaluation for pop and peek
    assign stored = LEN_W'(r_st);
    assign m1     = (stored < r_len) ? stored : r_len;
    assign n_cnt  = (m1 > LEN_W'(MAX_DELIVER)) ? DCW'(MAX_DELIVER) : DCW'(m1);
    assign total  = SW'(HEADER_BYTES) + SW'(stored);
    assign rp_sum = SW'(r_rp) + total;

    // Command execution
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_ra       = r_ra;
        n_free     = r_free;
        n_prem     = r_prem;
        n_hsh      = r_hsh;
        n_hcnt     = r_hcnt;
        n_st       = r_st;
        n_is_pop   = r_is_pop;
        n_len      = r_len;
        n_left     = r_left;
        n_inf      = 1'b0;
        n_inf_last = r_inf_last;
        wr_en      = 1'b0;
        wr_addr    = r_wp;
        wr_data    = i_cmd.data;
        rd_en      = 1'b0;
        rd_addr    = r_ra;
        o_cmd_pop  = 1'b0;
        res_push   = 1'b0;
        res_status = ST_OK;
        res_byte   = 1'b0;
        res_dout   = 8'd0;
        res_last   = 1'b1;

        // A returning data read goes out first
        if (r_inf) begin
            res_push = 1'b1;
            res_byte = 1'b1;
            res_dout = r_rd_data;
            res_last = r_inf_last;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && emit_ok) begin
                    o_cmd_pop = 1'b1;
                    res_push  = 1'b1;
                    if (i_cmd.kind == K_BAD) begin
                        res_status = ST_SEQ;
                    end else if (i_cmd.kind == K_DATA) begin
                        if (r_prem == '0) begin
                            res_status = ST_SEQ;
                        end else begin
                            wr_en  = 1'b1;
                            n_wp   = ptr_next(r_wp);
                            n_prem = r_prem - 1'b1;
                        end
                    end else if (r_prem != '0) begin
                        res_status = ST_SEQ;
                    end else if (i_cmd.kind == K_BEGIN) begin
                        if (!i_cmd.fits || (SW'(i_cmd.need) > SW'(r_free))) begin
                            res_status = ST_FULL;
                        end else begin
                            n_free  = r_free - FCW'(i_cmd.need);
                            n_prem  = i_cmd.len;
                            n_hsh   = i_cmd.len;
                            n_hcnt  = '0;
                            n_state = S_HWR;
                        end
                    end else if (i_cmd.kind == K_CLEAR) begin
                        n_rp   = r_wp;
                        n_free = FCW'(BUFFER_BYTES);
                    end else if (r_free >= FCW'(BUFFER_BYTES)) begin
                        res_status = ST_EMPTY;
                    end else begin
                        // pop or peek: fetch the header first
                        res_push = 1'b0;
                        n_is_pop = (i_cmd.kind == K_POP);
                        n_len    = i_cmd.len;
                        n_ra     = r_rp;
                        n_hcnt   = '0;
                        n_st     = '0;
                        n_state  = S_HRD;
                    end
                end
            end
            S_HWR: begin
                // Little-endian header, one byte a cycle
                wr_en   = 1'b1;
                wr_data = 8'(r_hsh);
                n_wp    = ptr_next(r_wp);
                n_hsh   = r_hsh >> 8;
                n_hcnt  = r_hcnt + 1'b1;
                if (r_hcnt == HCW'(HEADER_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_HRD: begin
                if (r_hcnt < HCW'(HEADER_BYTES)) begin
                    rd_en = 1'b1;
                    n_ra  = ptr_next(r_ra);
                end
                if (r_hcnt != '0) begin
                    n_st = (r_st >> 8) | (HDW'(r_rd_data) << (HDW - 8));
                end
                n_hcnt = r_hcnt + 1'b1;
                if (r_hcnt == HCW'(HEADER_BYTES)) begin
                    n_state = S_HEVAL;
                end
            end
            S_HEVAL: begin
                if ((n_cnt != '0) || emit_ok) begin
                    if (r_is_pop) begin
                        n_rp = (rp_sum >= SW'(BUFFER_BYTES)) ?
                               PW'(rp_sum - SW'(BUFFER_BYTES)) : PW'(rp_sum);
                        if (total > SW'(BUFFER_BYTES) - SW'(r_free)) begin
                            n_free = FCW'(BUFFER_BYTES);
                        end else begin
                            n_free = FCW'(SW'(r_free) + total);
                        end
                    end
                    n_left = n_cnt;
                    if (n_cnt == '0) begin
                        res_push = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state  = S_DATA;
                    end
                end
            end
            S_DATA: begin
                // One byte read a cycle while the output buffer has room
                if (slot_ok) begin
                    rd_en      = 1'b1;
                    n_ra       = ptr_next(r_ra);
                    n_left     = r_left - 1'b1;
                    n_inf      = 1'b1;
                    n_inf_last = (r_left == DCW'(1));
                    if (r_left == DCW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.status     = res_status;
        res.byte_valid = res_byte;
        res.data_out   = res_dout;
        res.last       = res_last;
        res.free_space = FREE_W'(n_free);
        res.is_empty   = (n_free == FCW'(BUFFER_BYTES));
    end

    // Ring memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ra       <= n_ra;
        r_hsh      <= n_hsh;
        r_hcnt     <= n_hcnt;
        r_st       <= n_st;
        r_is_pop   <= n_is_pop;
        r_len      <= n_len;
        r_left     <= n_left;
        r_inf_last <= n_inf_last;
        if (res_push) begin
            r_ob[r_ow] <= res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_free  <= FCW'(BUFFER_BYTES);
            r_prem  <= '0;
            r_inf   <= 1'b0;
            r_ow    <= 1'b0;
            r_or    <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_free  <= n_free;
            r_prem  <= n_prem;
            r_inf   <= n_inf;
            if (res_push) begin
                r_ow <= ~r_ow;
            end
            if (out_pop) begin
                r_or <= ~r_or;
            end
            r_ocnt <= r_ocnt + 2'(res_push) - 2'(out_pop);
        end
    end

    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_out_data  = r_ob[r_or];

endmodule

`default_nettype wire

// File: sv/variable_length_record_fifo.sv
// Top level of the variable-length record FIFO: front end, command queue
// and back end. Depends on vlrf_pkg, vlrf_front and vlrf_back.
//
//   channel   signals                               word
//   input     i_in_valid / o_in_ready / i_in_data    opcode, length, data byte
//   output    o_out_valid / i_out_ready / o_out_data  status, byte, last, free
//
// Data byte, clear and rejected operations complete in the back end's idle state.
// Begin push reserves space, then writes the header through the single memory
// write port one byte a cycle. Pop and peek fetch the header (S_HRD) and
// evaluate it (S_HEVAL), then read one delivered byte a cycle while the output
// buffer has room; each byte is registered from the memory before it goes out.
// Reset clears pointers, counts and the back-end state only; the store holds no data until written.
// A two-word command queue and a two-word output buffer let either side stall.
`default_nettype none

module variable_length_record_fifo #(
    parameter int unsigned BUFFER_BYTES = vlrf_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = vlrf_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_DELIVER  = vlrf_pkg::MAX_DELIVER_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  vlrf_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output vlrf_pkg::t_out  o_out_data
);
    import vlrf_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // Accept and classify
    vlrf_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    // Execute on the ring
    vlrf_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_DELIVER  (MAX_DELIVER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
